// File: design/carl_pkg.sv
// ----------------------------------------------------------------------------
// carl_pkg: shared types and constants for the command/ack/resend link
// Command text, carriage return code, window depth and the structs passed
// between the window cells, the window reduction and the link controller.
// ----------------------------------------------------------------------------
package carl_pkg;

    localparam int unsigned WINDOW_DEPTH = 5;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned TIMEOUT_W    = 16;

    localparam logic [BYTE_W-1:0]    CH_CR         = 8'h0D;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    // req_type codes
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Per-cell match flags, registered inside each window cell
    typedef struct packed {
        logic req_match;
        logic ack_match;
    } carl_flags_t;

    // Decoded command for the controller
    typedef struct packed {
        logic is_byte;
        logic start;
        logic ack;
    } carl_cmd_t;

    // "!RST#", oldest byte at position 0
    function automatic logic [BYTE_W-1:0] req_char(input int unsigned pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            0:       c = 8'h21; // '!'
            1:       c = 8'h52; // 'R'
            2:       c = 8'h53; // 'S'
            3:       c = 8'h54; // 'T'
            4:       c = 8'h23; // '#'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "!OK#" in the four newest positions; position 0 takes no part
    function automatic logic [BYTE_W-1:0] ack_char(input int unsigned pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            1:       c = 8'h21; // '!'
            2:       c = 8'h4F; // 'O'
            3:       c = 8'h4B; // 'K'
            4:       c = 8'h23; // '#'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/carl_cell.sv
// ----------------------------------------------------------------------------
// carl_cell: one byte position of the receive window
// Holds one byte, passes it on to the older neighbor on each shift and keeps
// registered flags telling whether its byte matches the command text.
// ----------------------------------------------------------------------------
module carl_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [carl_pkg::BYTE_W-1:0]  din,
    output logic [carl_pkg::BYTE_W-1:0]  dout,
    output carl_pkg::carl_flags_t        flags
);

    localparam logic [carl_pkg::BYTE_W-1:0] REQ_CHAR = carl_pkg::req_char(CELL_IDX);
    localparam logic [carl_pkg::BYTE_W-1:0] ACK_CHAR = carl_pkg::ack_char(CELL_IDX);
    localparam bit                          HAS_ACK  = (CELL_IDX != 0);

    logic [carl_pkg::BYTE_W-1:0] byte_reg;
    carl_pkg::carl_flags_t       flags_reg;
    carl_pkg::carl_flags_t       flags_next;

    always_comb
    begin
        flags_next.req_match = (din == REQ_CHAR);
        // oldest cell is outside the ack text, so it never blocks a match
        flags_next.ack_match = HAS_ACK ? (din == ACK_CHAR) : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg            <= '0;
            flags_reg.req_match <= 1'b0;
            flags_reg.ack_match <= !HAS_ACK;
        end
        else if (shift_en)
        begin
            byte_reg  <= din;
            flags_reg <= flags_next;
        end
    end

    assign dout  = byte_reg;
    assign flags = flags_reg;

endmodule

// File: design/carl_ctrl.sv
// ----------------------------------------------------------------------------
// carl_ctrl: link state, countdown and output register
// Tracks free/waiting, runs the acknowledge countdown on ticks and holds the
// result word until the sink takes it.
// ----------------------------------------------------------------------------
module carl_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  carl_pkg::carl_cmd_t            cmd,
    input  logic [carl_pkg::BYTE_W-1:0]    adc_sample,
    input  logic [carl_pkg::TIMEOUT_W-1:0] timeout_ticks,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           send_now,
    output logic                           is_resend,
    output logic [carl_pkg::BYTE_W-1:0]    report_value,
    output logic                           waiting
);

    logic                           accept;
    logic                           wait_reg,    wait_next;
    logic [carl_pkg::TIMEOUT_W-1:0] count_reg,   count_next;
    logic [carl_pkg::BYTE_W-1:0]    latched_reg, latched_next;
    logic                           send_next, resend_next;
    logic [carl_pkg::BYTE_W-1:0]    value_next;
    logic                           ovalid_reg;
    logic                           send_reg, resend_reg;
    logic [carl_pkg::BYTE_W-1:0]    value_reg;
    logic                           expired;

    assign in_ready = !ovalid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    // countdown of 0 or 1 expires on this tick
    assign expired  = (count_reg[carl_pkg::TIMEOUT_W-1:1] == '0);

    always_comb
    begin
        wait_next    = wait_reg;
        count_next   = count_reg;
        latched_next = latched_reg;
        send_next    = 1'b0;
        resend_next  = 1'b0;
        value_next   = '0;
        if (cmd.start)
        begin
            latched_next = adc_sample;
            wait_next    = 1'b1;
            count_next   = timeout_ticks;
            send_next    = 1'b1;
            value_next   = adc_sample;
        end
        else if (cmd.ack)
        begin
            wait_next = 1'b0;
        end
        else if (!cmd.is_byte && wait_reg)
        begin
            if (expired)
            begin
                send_next   = 1'b1;
                resend_next = 1'b1;
                value_next  = latched_reg;
                count_next  = timeout_ticks;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg    <= 1'b0;
            count_reg   <= '0;
            latched_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wait_reg    <= wait_next;
                count_reg   <= count_next;
                latched_reg <= latched_next;
                ovalid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            send_reg   <= send_next;
            resend_reg <= resend_next;
            value_reg  <= value_next;
        end
    end

    assign out_valid    = ovalid_reg;
    assign send_now     = send_reg;
    assign is_resend    = resend_reg;
    assign report_value = value_reg;
    assign waiting      = wait_reg;

    a_resend_is_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_resend |-> send_now)
        else $error("resend without send");

    a_idle_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_now |-> report_value == '0)
        else $error("report value set on a word without send");

    a_send_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_now |-> waiting)
        else $error("sample sent while link is free");

    a_start_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.start |=> wait_reg && count_reg == $past(timeout_ticks))
        else $error("request did not load the wait state");

    a_free_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cmd.is_byte && !wait_reg |=> $stable(count_reg) && !wait_reg)
        else $error("tick while free changed the countdown");

endmodule

// File: design/command_ack_resend_link_unit.sv
// ----------------------------------------------------------------------------
// command_ack_resend_link_unit: serial command link with ack timeout/resend
// Watches received bytes for "!RST#"+CR (send the sample, wait for ack) and
// "!OK#"+CR (ack), and resends the latched sample on each countdown expiry.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Word contents
//  -------   ---  -------------------  ---------------------------------------
//  in        in   in_valid/in_ready    req_type, rx_byte, adc_sample
//  out       out  out_valid/out_ready  send_now, is_resend, report_value,
//                                      waiting
//  cfg       in   cfg_wr_en            cfg_wr_data -> timeout_ticks
//
//  One input word per cycle while the output is not stalled; each word
//  produces exactly one output word, in the cycle after acceptance.
//  The throughput limit is the single output register: a new word is taken
//  whenever that register is empty or is being drained in the same cycle.
//  A stalled output holds its word and backs up the input via in_ready.
//  Reset (rst_n low, asynchronous) clears the window, the link state, the
//  countdown and latched sample, and sets timeout_ticks to 30.
//
module command_ack_resend_link_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // input words
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [carl_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [carl_pkg::BYTE_W-1:0]    adc_sample,
    // result words
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           send_now,
    output logic                           is_resend,
    output logic [carl_pkg::BYTE_W-1:0]    report_value,
    output logic                           waiting,
    // timeout register
    input  logic                           cfg_wr_en,
    input  logic [carl_pkg::TIMEOUT_W-1:0] cfg_wr_data
);

    localparam int unsigned DEPTH = carl_pkg::WINDOW_DEPTH;

    logic [carl_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                           shift_en;
    logic [carl_pkg::BYTE_W-1:0]    chain [DEPTH+1];
    carl_pkg::carl_flags_t          flags [DEPTH];
    logic [DEPTH-1:0]               req_hits;
    logic [DEPTH-1:0]               ack_hits;
    logic                           is_cr;
    carl_pkg::carl_cmd_t            cmd;

    // Timeout register; a new value is used at the next countdown load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= carl_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Window: only received bytes shift in, ticks leave it alone
    assign shift_en     = in_valid && in_ready && (req_type == carl_pkg::REQ_BYTE);
    assign chain[DEPTH] = rx_byte;

    // Cell DEPTH-1 holds the newest byte, cell 0 the oldest; bytes fall off
    // the old end, there is no wrap.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        carl_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .din      (chain[i+1]),
            .dout     (chain[i]),
            .flags    (flags[i])
        );
        assign req_hits[i] = flags[i].req_match;
        assign ack_hits[i] = flags[i].ack_match;
    end

    // Command decode compares against the window before this byte goes in.
    // A full request takes priority; anything else ending in CR is ignored.
    always_comb
    begin
        is_cr       = (rx_byte == carl_pkg::CH_CR);
        cmd.is_byte = (req_type == carl_pkg::REQ_BYTE);
        cmd.start   = cmd.is_byte && is_cr && (&req_hits);
        cmd.ack     = cmd.is_byte && is_cr && !(&req_hits) && (&ack_hits);
    end

    carl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .adc_sample    (adc_sample),
        .timeout_ticks (timeout_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .send_now      (send_now),
        .is_resend     (is_resend),
        .report_value  (report_value),
        .waiting       (waiting)
    );

endmodule
